// ----- rtl/core/windowed_rms_envelope_assert.svh -----
// Assertion macros used by the windowed RMS envelope RTL.
// No dependencies; included inside module bodies.
`ifndef WINDOWED_RMS_ENVELOPE_ASSERT_SVH
`define WINDOWED_RMS_ENVELOPE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WRE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("windowed_rms_envelope check failed");

// Next-cycle implication, disabled during reset.
`define WRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("windowed_rms_envelope check failed");

`endif

// ----- rtl/core/wre_pkg.sv -----
// Shared types, codes and sample conversion for the windowed RMS envelope.
// No dependencies.
package wre_pkg;

	localparam int SAMPLE_W = 32;
	localparam int Q23_W    = 24;
	localparam int ACC_W    = 56;
	localparam int FRAME_W  = 20;
	localparam int LEVEL_W  = 24;
	localparam int CFG_W    = 20;
	localparam int CFG_IDX_W = 2;
	localparam int MONO_SUM_W = 27;

	localparam logic [1:0] CMD_FRAME = 2'd0;
	localparam logic [1:0] CMD_FLUSH = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FORMAT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd2;

	localparam logic [2:0] FMT_F32 = 3'd0;
	localparam logic [2:0] FMT_S16 = 3'd1;
	localparam logic [2:0] FMT_S32 = 3'd2;
	localparam logic [2:0] FMT_S24 = 3'd3;
	localparam logic [2:0] FMT_U8  = 3'd4;

	localparam logic [2:0]         FORMAT_RST   = FMT_F32;
	localparam logic [3:0]         CHANNELS_RST = 4'd2;
	localparam logic [FRAME_W-1:0] WINDOW_RST   = 20'd4410;

	typedef struct packed {
		logic [1:0]          cmd;
		logic [SAMPLE_W-1:0] sample_ch0;
		logic [SAMPLE_W-1:0] sample_ch1;
		logic [SAMPLE_W-1:0] sample_ch2;
		logic [SAMPLE_W-1:0] sample_ch3;
		logic [SAMPLE_W-1:0] sample_ch4;
		logic [SAMPLE_W-1:0] sample_ch5;
		logic [SAMPLE_W-1:0] sample_ch6;
		logic [SAMPLE_W-1:0] sample_ch7;
	} in_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] rms_level;
		logic [LEVEL_W-1:0] peak_level;
		logic [LEVEL_W-1:0] window_number;
		logic               partial_window;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic conv;
		logic sum;
		logic div_mono;
		logic div_window;
		logic square;
		logic acc;
		logic root;
		logic emit;
		logic partial;
	} wre_cmd_t;

	typedef struct packed {
		logic div_done;
		logic root_done;
		logic close;
		logic held_zero;
		logic out_free;
	} wre_status_t;

	// Raw sample to signed Q1.23; float truncates toward zero and saturates.
	function automatic logic signed [Q23_W-1:0] to_q23(
		input logic [SAMPLE_W-1:0] raw,
		input logic [2:0]          fmt
	);
		logic [7:0]        ex;
		logic [22:0]       man;
		logic [7:0]        sh;
		logic [Q23_W-1:0]  mag;
		logic signed [Q23_W-1:0] res;
		ex  = raw[30:23];
		man = raw[22:0];
		sh  = 8'd127 - ex;
		mag = '0;
		res = '0;
		case (fmt)
			FMT_F32: begin
				if (ex == 8'hFF && man != '0) begin
					res = '0;
				end else if (ex >= 8'd127) begin
					res = raw[31] ? 24'sh800000 : 24'sh7FFFFF;
				end else if (ex == 8'd0) begin
					res = '0;
				end else begin
					mag = (sh >= 8'd24) ? '0 : ({1'b1, man} >> sh[4:0]);
					res = raw[31] ? -$signed(mag) : $signed(mag);
				end
			end
			FMT_S16: res = $signed({raw[15:0], 8'h00});
			FMT_S32: res = $signed(raw[31:8]);
			FMT_S24: res = $signed(raw[23:0]);
			FMT_U8:  res = $signed({~raw[7], raw[6:0], 16'h0000});
			default: res = '0;
		endcase
		return res;
	endfunction

endpackage

// ----- rtl/core/windowed_rms_envelope.sv -----
// A frame item steps through conversion, mono sum, mono divide, square and accumulate;
// closing a window adds the window divide, the square root and the emit step. A flush
// with frames held runs the window divide, root and emit; clear, unknown commands and an empty
// flush stay idle. Both divides share one bit-serial divider; a stalled output holds emit.
// One result register lets the next item enter while a result waits for transfer.
// Asynchronous active-low reset empties the accumulator, peak, window count and
// output, and restores format f32, two channels and a 4410-frame window.
module windowed_rms_envelope #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [wre_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wre_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  wre_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output wre_pkg::out_item_t            out_data
);
	import wre_pkg::*;

	wre_cmd_t    ctl;
	wre_status_t status;

	// Sequencer: accepts one transfer when idle and walks it through the datapath.
	wre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_cmd   (in_data.cmd),
		.in_stall (in_stall),
		.status   (status),
		.ctl      (ctl)
	);

	// Datapath: conversion lanes, mono divide, square, accumulate, RMS.
	wre_datapath #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.ctl       (ctl),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ----- rtl/core/wre_ctrl.sv -----
// Sequencer for the windowed RMS envelope: steps the datapath through one item.
// Depends on wre_pkg.
module wre_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          in_cmd,
	output logic                in_stall,
	input  wre_pkg::wre_status_t status,
	output wre_pkg::wre_cmd_t    ctl
);
	import wre_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_CONV, S_SUM, S_MSTART, S_MWAIT, S_SQR, S_ACC,
		S_WSTART, S_WWAIT, S_RSTART, S_RWAIT, S_EMIT
	} state_t;

	state_t state_q;
	logic   partial_q;
	logic   accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			partial_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (in_cmd)
							CMD_FRAME: begin
								state_q   <= S_CONV;
								partial_q <= 1'b0;
							end
							CMD_FLUSH: begin
								if (!status.held_zero) begin
									state_q   <= S_WSTART;
									partial_q <= 1'b1;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_CONV:   state_q <= S_SUM;
				S_SUM:    state_q <= S_MSTART;
				S_MSTART: state_q <= S_MWAIT;
				S_MWAIT:  if (status.div_done) state_q <= S_SQR;
				S_SQR:    state_q <= S_ACC;
				S_ACC:    state_q <= status.close ? S_WSTART : S_IDLE;
				S_WSTART: state_q <= S_WWAIT;
				S_WWAIT:  if (status.div_done) state_q <= S_RSTART;
				S_RSTART: state_q <= S_RWAIT;
				S_RWAIT:  if (status.root_done) state_q <= S_EMIT;
				S_EMIT:   if (status.out_free) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		ctl            = '0;
		ctl.load       = accept;
		ctl.clear      = accept && (in_cmd == CMD_CLEAR);
		ctl.conv       = (state_q == S_CONV);
		ctl.sum        = (state_q == S_SUM);
		ctl.div_mono   = (state_q == S_MSTART);
		ctl.square     = (state_q == S_SQR);
		ctl.acc        = (state_q == S_ACC);
		ctl.div_window = (state_q == S_WSTART);
		ctl.root       = (state_q == S_RSTART);
		ctl.emit       = (state_q == S_EMIT) && status.out_free;
		ctl.partial    = partial_q;
	end

endmodule

// ----- rtl/core/wre_datapath.sv -----
// Datapath: config registers, conversion, shared divider, square root, output.
// Depends on wre_pkg and windowed_rms_envelope_assert.svh.
module wre_datapath #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [wre_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wre_pkg::CFG_W-1:0]     cfg_data,
	input  wre_pkg::in_item_t     in_data,
	input  wre_pkg::wre_cmd_t     ctl,
	output wre_pkg::wre_status_t  status,
	output logic                  out_valid,
	input  logic                  out_stall,
	output wre_pkg::out_item_t    out_data
);
	import wre_pkg::*;
	`include "windowed_rms_envelope_assert.svh"

	localparam int DIV_STEPS  = ACC_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam int ROOT_STEPS = 32;
	localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
	localparam logic [3:0] MAX_CH = 4'(MAX_CHANNELS);

	logic [2:0]          fmt_q;
	logic [3:0]          chan_q;
	logic [FRAME_W-1:0]  win_q;

	logic [SAMPLE_W-1:0] raw_q [8];
	logic signed [Q23_W-1:0] conv_q [MAX_CHANNELS];
	logic signed [MONO_SUM_W-1:0] sum_q;
	logic [2*Q23_W-1:0]  prod_q;
	logic [ACC_W-1:0]    square_sum_q;
	logic [FRAME_W-1:0]  frames_held_q;
	logic [LEVEL_W-1:0]  peak_q;
	logic [LEVEL_W-1:0]  windows_q;

	logic [ACC_W-1:0]    dvd_q;
	logic [FRAME_W-1:0]  rem_q;
	logic [FRAME_W-1:0]  dsr_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                div_busy_q;

	logic [63:0]         rval_q;
	logic [33:0]         rrem_q;
	logic [31:0]         root_q;
	logic [ROOT_CNT_W-1:0] root_cnt_q;
	logic                root_busy_q;

	logic                out_valid_q;
	out_item_t           out_q;

	logic [3:0]          n_eff;
	logic [FRAME_W-1:0]  win_eff;
	logic signed [MONO_SUM_W-1:0] sum_c;
	logic [MONO_SUM_W-1:0] sum_mag;
	logic [FRAME_W:0]    div_shift;
	logic                div_ge;
	logic [33:0]         root_shift;
	logic [33:0]         root_trial;
	logic                root_ge;
	logic [ACC_W:0]      acc_sum;
	logic [FRAME_W-1:0]  held_next;
	logic [LEVEL_W-1:0]  rms_sat;

	assign n_eff   = (chan_q == 4'd0) ? 4'd1 : ((chan_q > MAX_CH) ? MAX_CH : chan_q);
	assign win_eff = (win_q == '0) ? FRAME_W'(1) : win_q;

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < MAX_CHANNELS; i++) begin
			sum_c = sum_c + MONO_SUM_W'(conv_q[i]);
		end
	end
	assign sum_mag = sum_q[MONO_SUM_W-1] ? MONO_SUM_W'(-sum_q) : MONO_SUM_W'(sum_q);

	assign div_shift = {rem_q, dvd_q[ACC_W-1]};
	assign div_ge    = (div_shift >= {1'b0, dsr_q});

	assign root_shift = {rrem_q[31:0], rval_q[63:62]};
	assign root_trial = {root_q, 2'b01};
	assign root_ge    = (root_shift >= root_trial);

	assign acc_sum   = {1'b0, square_sum_q} + (ACC_W+1)'(prod_q[2*Q23_W-1:10]);
	assign held_next = frames_held_q + FRAME_W'(1);
	assign rms_sat   = (root_q[31:LEVEL_W] != '0) ? '1 : root_q[LEVEL_W-1:0];

	assign status.div_done  = div_busy_q && (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign status.root_done = root_busy_q && (root_cnt_q == ROOT_CNT_W'(ROOT_STEPS - 1));
	assign status.close     = (held_next >= win_eff) || (held_next == '0);
	assign status.held_zero = (frames_held_q == '0);
	assign status.out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q  <= FORMAT_RST;
			chan_q <= CHANNELS_RST;
			win_q  <= WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FORMAT:   fmt_q  <= cfg_data[2:0];
				REG_CHANNELS: chan_q <= cfg_data[3:0];
				REG_WINDOW:   win_q  <= cfg_data;
				default:      ;
			endcase
		end
	end

	// Payload path: samples, lanes, sum, product
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			raw_q[0] <= in_data.sample_ch0;
			raw_q[1] <= in_data.sample_ch1;
			raw_q[2] <= in_data.sample_ch2;
			raw_q[3] <= in_data.sample_ch3;
			raw_q[4] <= in_data.sample_ch4;
			raw_q[5] <= in_data.sample_ch5;
			raw_q[6] <= in_data.sample_ch6;
			raw_q[7] <= in_data.sample_ch7;
		end
		if (ctl.conv) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				conv_q[i] <= (4'(i) < n_eff) ? to_q23(raw_q[i], fmt_q) : '0;
			end
		end
		if (ctl.sum) begin
			sum_q <= sum_c;
		end
		if (ctl.square) begin
			prod_q <= dvd_q[Q23_W-1:0] * dvd_q[Q23_W-1:0];
		end
	end

	// Shared restoring divider, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q  <= '0;
		end else if (ctl.div_mono || ctl.div_window) begin
			div_busy_q <= 1'b1;
			div_cnt_q  <= '0;
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			if (status.div_done) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.div_mono) begin
			dvd_q <= ACC_W'(sum_mag);
			dsr_q <= FRAME_W'(n_eff);
			rem_q <= '0;
		end else if (ctl.div_window) begin
			dvd_q <= square_sum_q;
			dsr_q <= frames_held_q;
			rem_q <= '0;
		end else if (div_busy_q) begin
			dvd_q <= {dvd_q[ACC_W-2:0], div_ge};
			rem_q <= div_ge ? FRAME_W'(div_shift - {1'b0, dsr_q}) : div_shift[FRAME_W-1:0];
		end
	end

	// Digit-by-digit square root, one result bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_busy_q <= 1'b0;
			root_cnt_q  <= '0;
		end else if (ctl.root) begin
			root_busy_q <= 1'b1;
			root_cnt_q  <= '0;
		end else if (root_busy_q) begin
			root_cnt_q <= root_cnt_q + ROOT_CNT_W'(1);
			if (status.root_done) begin
				root_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.root) begin
			rval_q <= {dvd_q[51:0], 12'h000};
			rrem_q <= '0;
			root_q <= '0;
		end else if (root_busy_q) begin
			rval_q <= {rval_q[61:0], 2'b00};
			rrem_q <= root_ge ? (root_shift - root_trial) : root_shift;
			root_q <= {root_q[30:0], root_ge};
		end
	end

	// Track state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			square_sum_q  <= '0;
			frames_held_q <= '0;
			peak_q        <= '0;
			windows_q     <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (ctl.clear) begin
				square_sum_q  <= '0;
				frames_held_q <= '0;
				peak_q        <= '0;
				windows_q     <= '0;
			end else if (ctl.acc) begin
				square_sum_q  <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
				frames_held_q <= (held_next == '0) ? '1 : held_next;
			end else if (ctl.emit) begin
				square_sum_q  <= '0;
				frames_held_q <= '0;
				if (rms_sat > peak_q) begin
					peak_q <= rms_sat;
				end
				if (windows_q != '1) begin
					windows_q <= windows_q + LEVEL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_q.rms_level      <= rms_sat;
			out_q.peak_level     <= (rms_sat > peak_q) ? rms_sat : peak_q;
			out_q.window_number  <= windows_q;
			out_q.partial_window <= ctl.partial;
		end
	end

	`WRE_ASSERT_SAME(a_one_unit_busy, clk, arst_n, 1'b1, $onehot0({div_busy_q, root_busy_q}))
	`WRE_ASSERT_NEXT(a_emit_clears, clk, arst_n, ctl.emit,
		square_sum_q == '0 && frames_held_q == '0 && out_valid_q)
	`WRE_ASSERT_SAME(a_rms_below_peak, clk, arst_n, $rose(out_valid_q),
		out_q.rms_level <= out_q.peak_level)
	`WRE_ASSERT_NEXT(a_peak_holds, clk, arst_n, !ctl.clear, peak_q >= $past(peak_q))

endmodule

// ----- tb/tb_windowed_rms_envelope.sv -----
// Self-checking testbench for windowed_rms_envelope: directed and random frame traffic,
// an in-bench level predictor and an in-order result checker.
// Depends on wre_pkg and the windowed_rms_envelope RTL only.
module tb_windowed_rms_envelope;
	timeunit 1ns;
	timeprecision 1ps;
	import wre_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 200;
	localparam longint unsigned SQ_SUM_MAX = 64'h00FF_FFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;

	windowed_rms_envelope dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of registers and accumulator state
	logic [2:0] m_format;
	logic [3:0] m_channels;
	logic [19:0] m_window;
	longint unsigned m_sq_sum;
	logic [19:0] m_held;
	logic [23:0] m_peak;
	logic [23:0] m_windows;

	out_item_t levels_due[$];
	logic [31:0] lane[8];

	int errors = 0;
	int items_sent = 0;
	int levels_checked = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	longint cycle = 0;
	longint hold_until = 0;
	int idle_cycles = 0;

	// Convert one raw sample to signed Q1.23 per the active format.
	function automatic longint q23_of(logic [31:0] raw, logic [2:0] fmt);
		logic [7:0] ex;
		logic [22:0] man;
		int sh;
		longint mag;
		ex = raw[30:23];
		man = raw[22:0];
		case (fmt)
			FMT_F32: begin
				if (ex == 8'hFF && man != '0) return 0;
				if (ex >= 8'd127) return raw[31] ? -64'sd8388608 : 64'sd8388607;
				if (ex == 8'd0) return 0;
				sh = 127 - int'(ex);
				mag = (sh >= 24) ? 0 : longint'({1'b1, man} >> sh);
				return raw[31] ? -mag : mag;
			end
			FMT_S16: return longint'($signed(raw[15:0])) * 256;
			FMT_S32: return longint'($signed(raw[31:8]));
			FMT_S24: return longint'($signed(raw[23:0]));
			FMT_U8: return (longint'(raw[7:0]) - 128) * 65536;
			default: return 0;
		endcase
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Close the running window and queue the level it produces.
	function automatic void close_window(logic partial);
		longint unsigned div;
		longint unsigned q;
		longint unsigned rms;
		out_item_t lv;
		div = (m_held != 0) ? longint'(m_held) : 1;
		q = m_sq_sum / div;
		rms = int_sqrt(q << 12);
		if (rms > 64'hFFFFFF) rms = 64'hFFFFFF;
		if (rms[23:0] > m_peak) m_peak = rms[23:0];
		lv.rms_level = rms[23:0];
		lv.peak_level = m_peak;
		lv.window_number = m_windows;
		lv.partial_window = partial;
		levels_due.push_back(lv);
		if (m_windows != 24'hFFFFFF) m_windows++;
		m_sq_sum = 0;
		m_held = '0;
	endfunction

	function automatic void meter_step(in_item_t it);
		logic [31:0] s[8];
		int n;
		int w;
		longint sum;
		longint mono;
		longint unsigned sq;
		s = '{it.sample_ch0, it.sample_ch1, it.sample_ch2, it.sample_ch3,
			it.sample_ch4, it.sample_ch5, it.sample_ch6, it.sample_ch7};
		case (it.cmd)
			CMD_FRAME: begin
				n = (m_channels == 0) ? 1 : (m_channels > 8) ? 8 : int'(m_channels);
				w = (m_window == 0) ? 1 : int'(m_window);
				sum = 0;
				for (int c = 0; c < n; c++) sum += q23_of(s[c], m_format);
				mono = sum / n;
				sq = longint'(mono * mono) >> 10;
				if (m_sq_sum > SQ_SUM_MAX - sq) m_sq_sum = SQ_SUM_MAX;
				else m_sq_sum += sq;
				m_held = m_held + 20'd1;
				if (int'(m_held) >= w || m_held == 0) begin
					if (m_held == 0) m_held = 20'hFFFFF;
					close_window(1'b0);
				end
			end
			CMD_FLUSH: if (m_held != 0) close_window(1'b1);
			CMD_CLEAR: begin
				m_sq_sum = 0;
				m_held = '0;
				m_peak = '0;
				m_windows = '0;
			end
			default: ;
		endcase
	endfunction

	task automatic flag_mismatch(string field, logic [23:0] got, logic [23:0] want);
		$display("MISMATCH %s at cycle %0d: got %h want %h", field, cycle, got, want);
		errors++;
	endtask

	// Results and stall are stable at the falling edge; a transfer here lands at the next rise.
	always @(negedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (levels_due.size() == 0) begin
				$display("MISMATCH unexpected level at cycle %0d: %p", cycle, out_data);
				errors++;
			end else begin
				want = levels_due.pop_front();
				levels_checked++;
				if (out_data.rms_level !== want.rms_level)
					flag_mismatch("rms_level", out_data.rms_level, want.rms_level);
				if (out_data.peak_level !== want.peak_level)
					flag_mismatch("peak_level", out_data.peak_level, want.peak_level);
				if (out_data.window_number !== want.window_number)
					flag_mismatch("window_number", out_data.window_number, want.window_number);
				if (out_data.partial_window !== want.partial_window)
					flag_mismatch("partial_window", out_data.partial_window,
						want.partial_window);
			end
		end
	end

	// Watchdog: count cycles in which neither channel moves a transfer.
	always @(negedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("tb_windowed_rms_envelope: errors");
			$finish;
		end
	end

	// Receiver: hold off during a requested window, otherwise stall at random.
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle < hold_until)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Offer one item built from lane[]; return on the edge that completes its transfer.
	task automatic send_item(logic [1:0] cmd);
		in_item_t it;
		bit taken;
		int gap;
		it = '{cmd, lane[0], lane[1], lane[2], lane[3], lane[4], lane[5], lane[6], lane[7]};
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		meter_step(it);
		items_sent++;
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for every queued level, then let a result-free item finish inside the block.
	task automatic drain();
		stop_sending();
		while (levels_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_FORMAT: m_format = val[2:0];
			REG_CHANNELS: m_channels = val[3:0];
			REG_WINDOW: m_window = val[19:0];
			default: ;
		endcase
	endtask

	task automatic fill_lanes(logic [31:0] v);
		for (int c = 0; c < 8; c++) lane[c] = v;
	endtask

	task automatic random_lanes();
		for (int c = 0; c < 8; c++) begin
			case ($urandom_range(9))
				0: lane[c] = 32'hFFFF_FFFF;
				1: lane[c] = 32'h8000_0000;
				2: lane[c] = 32'h7FFF_FFFF;
				3: lane[c] = 32'h0000_0000;
				4: lane[c] = {$urandom_range(1) ? 1'b1 : 1'b0, 8'd120 + 8'($urandom_range(7)),
					23'($urandom)};
				default: lane[c] = $urandom;
			endcase
		end
	endtask

	// Default registers: a short stretch of frames flushed as a partial window.
	task automatic test_reset_defaults();
		fill_lanes(32'h3F00_0000);
		send_item(CMD_FLUSH);
		send_item(CMD_FRAME);
		fill_lanes(32'hBE80_0000);
		send_item(CMD_FRAME);
		send_item(CMD_UNUSED);
		send_item(CMD_FLUSH);
		send_item(CMD_FLUSH);
		send_item(CMD_CLEAR);
		drain();
	endtask

	// Extremes of every format, one-frame windows so each frame yields a level.
	task automatic test_formats();
		logic [31:0] f32_cases[10] = '{32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000,
			32'hFF80_0000, 32'h7FC0_0000, 32'h3F7F_FFFF, 32'hBF00_0001, 32'h3380_0000,
			32'h0000_0001, 32'h3300_0000};
		write_reg(REG_WINDOW, 20'd1);
		write_reg(REG_CHANNELS, 20'd8);
		foreach (f32_cases[i]) begin
			fill_lanes(f32_cases[i]);
			lane[7] = 32'h0000_0000;
			send_item(CMD_FRAME);
		end
		for (int f = 1; f < 6; f++) begin
			write_reg(REG_FORMAT, 20'(f));
			fill_lanes(32'h8000_0080);
			lane[0] = 32'h0080_8000;
			send_item(CMD_FRAME);
			fill_lanes(32'h7FFF_FFFF);
			send_item(CMD_FRAME);
		end
		write_reg(REG_FORMAT, 20'(FMT_S24));
		write_reg(REG_CHANNELS, 20'd0);
		fill_lanes(32'h0080_0000);
		send_item(CMD_FRAME);
		write_reg(REG_CHANNELS, 20'd15);
		send_item(CMD_FRAME);
		drain();
	endtask

	// Window length edge cases: zero, shortened mid-window, and the widest window.
	task automatic test_window_lengths();
		write_reg(REG_CHANNELS, 20'd1);
		write_reg(REG_WINDOW, 20'd0);
		fill_lanes(32'h007F_FFFF);
		send_item(CMD_FRAME);
		send_item(CMD_FRAME);
		write_reg(REG_WINDOW, 20'd8);
		repeat (5) begin
			random_lanes();
			send_item(CMD_FRAME);
		end
		write_reg(REG_WINDOW, 20'd2);
		send_item(CMD_FRAME);
		write_reg(REG_WINDOW, 20'hFFFFF);
		repeat (3) begin
			random_lanes();
			send_item(CMD_FRAME);
		end
		send_item(CMD_FLUSH);
		send_item(CMD_CLEAR);
		drain();
	endtask

	// Starve the output for a long stretch so the block backs up onto its input.
	task automatic test_backpressure();
		write_reg(REG_FORMAT, 20'(FMT_S32));
		write_reg(REG_CHANNELS, 20'd3);
		write_reg(REG_WINDOW, 20'd1);
		hold_until = cycle + 600;
		repeat (30) begin
			random_lanes();
			send_item(CMD_FRAME);
		end
		drain();
	endtask

	// Random traffic in phases; registers change only between phases.
	task automatic test_random(int count);
		int cmd_pick;
		int sent;
		sent = 0;
		while (sent < count) begin
			write_reg(REG_FORMAT, 20'($urandom_range(7)));
			write_reg(REG_CHANNELS, 20'($urandom_range(15)));
			write_reg(REG_WINDOW, ($urandom_range(9) == 0) ? 20'($urandom_range(13, 60))
				: 20'($urandom_range(0, 12)));
			repeat (60) begin
				random_lanes();
				cmd_pick = $urandom_range(99);
				if (cmd_pick < 82) send_item(CMD_FRAME);
				else if (cmd_pick < 91) send_item(CMD_FLUSH);
				else if (cmd_pick < 96) send_item(CMD_CLEAR);
				else send_item(CMD_UNUSED);
				if (cmd_pick < 96) sent++;
			end
		end
	endtask

	initial begin
		m_format = FORMAT_RST;
		m_channels = CHANNELS_RST;
		m_window = WINDOW_RST;
		m_sq_sum = 0;
		m_held = '0;
		m_peak = '0;
		m_windows = '0;
		fill_lanes('0);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_formats();
		test_window_lengths();

		send_idle_pct = 28;
		recv_idle_pct = 70;
		test_backpressure();
		test_random(220);
		send_idle_pct = 70;
		recv_idle_pct = 28;
		test_random(220);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(220);

		// Final drain; the watchdog bounds it.
		drain();
		$display("covered %0d transfers in, %0d window levels checked", items_sent,
			levels_checked);
		$display("formats f32/s16/s32/s24/u8/unknown, channel and window extremes, stalls");
		if (errors == 0)
			$display("tb_windowed_rms_envelope: clean");
		else
			$display("tb_windowed_rms_envelope: errors");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/wre_pkg.sv
rtl/core/wre_ctrl.sv
rtl/core/wre_datapath.sv
rtl/core/windowed_rms_envelope.sv
tb/tb_windowed_rms_envelope.sv
